FILE: hw/rtl/patc_pkg.sv
package patc_pkg;

  // Fixed parameter defaults
  localparam int ADDRESS_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH          = 2;

  // Field widths
  localparam int COUNT_W = 6;   // up to 32 counter bits may land on one position
  localparam int SUM_W   = 20;  // fourteen 16-bit words fit in 20 bits

  // Constant header words
  localparam logic [15:0] PROTO_WORD        = 16'h0006;
  localparam logic [15:0] TCP_LEN_WORD      = 16'd20;
  localparam logic [15:0] OFFSET_FLAGS_WORD = 16'h5002;

  // Register reset values
  localparam logic [31:0] BASE_ADDRESS_RESET = 32'd0;
  localparam logic [5:0]  HOST_BITS_RESET    = 6'd8;
  localparam logic [15:0] DEST_PORT_RESET    = 16'd0;
  localparam logic [15:0] WINDOW_SIZE_RESET  = 16'd8192;

  // Register indexes
  typedef enum logic [1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_HOST_BITS    = 2'd1,
    REG_DEST_PORT    = 2'd2,
    REG_WINDOW_SIZE  = 2'd3
  } cfg_reg_t;

  // Commands
  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_GENERATE = 1'b1
  } command_t;

endpackage

FILE: hw/rtl/patc_front.sv
module patc_front #(
  parameter int ADDRESS_BITS = patc_pkg::ADDRESS_BITS_DEFAULT,
  parameter int QW = 6 * ADDRESS_BITS + patc_pkg::SUM_W
) (
  input  logic          clk,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [4:0]    perm_index,
  input  logic [4:0]    perm_target,
  input  logic [31:0]   counter,
  input  logic [31:0]   source_address,
  input  logic [15:0]   source_port,
  input  logic [31:0]   sequence_number,
  input  logic [31:0]   ack_number,
  input  logic [5:0]    host_bits,
  input  logic [15:0]   dest_port,
  input  logic [15:0]   window_size,
  output logic          push,
  output logic [QW-1:0] push_data,
  input  logic          queue_full
);
  import patc_pkg::*;

  localparam logic [5:0] ADDR_BITS_W = 6'(ADDRESS_BITS);

  // 32-bit population count as a five-level adder tree
  function automatic logic [COUNT_W-1:0] popcount32(input logic [31:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  logic [4:0]  bit_permutation [32];
  logic        accept;
  logic [5:0]  n_bits;
  logic [31:0] active;
  logic [COUNT_W-1:0][ADDRESS_BITS-1:0] vecs;
  logic [SUM_W-1:0] partial;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (command == CMD_GENERATE);

  // Permutation table: written by load beats, no reset
  always_ff @(posedge clk) begin
    if (accept && (command == CMD_LOAD)) begin
      bit_permutation[perm_index] <= perm_target;
    end
  end

  // Counter bits that take part
  assign n_bits = (host_bits > ADDR_BITS_W) ? ADDR_BITS_W : host_bits;

  always_comb begin
    for (int y = 0; y < 32; y++) begin
      active[y] = counter[y] && (6'(y) < n_bits);
    end
  end

  // Per-position hit counts, split into bit-plane vectors
  always_comb begin
    logic [31:0]          hits;
    logic [COUNT_W-1:0]   cnt;
    vecs = '0;
    for (int p = 0; p < ADDRESS_BITS; p++) begin
      for (int y = 0; y < 32; y++) begin
        hits[y] = active[y] && (bit_permutation[y] == 5'(p));
      end
      cnt = popcount32(hits);
      for (int k = 0; k < COUNT_W; k++) begin
        vecs[k][p] = cnt[k];
      end
    end
  end

  // Header words that do not depend on the destination
  assign partial = SUM_W'(source_address[31:16]) + SUM_W'(source_address[15:0])
                 + SUM_W'(PROTO_WORD) + SUM_W'(TCP_LEN_WORD)
                 + SUM_W'(source_port) + SUM_W'(dest_port)
                 + SUM_W'(sequence_number[31:16]) + SUM_W'(sequence_number[15:0])
                 + SUM_W'(ack_number[31:16]) + SUM_W'(ack_number[15:0])
                 + SUM_W'(OFFSET_FLAGS_WORD) + SUM_W'(window_size);

  assign push_data = {vecs, partial};

endmodule

FILE: hw/rtl/patc_queue.sv
module patc_queue #(
  parameter int QW = 6 * patc_pkg::ADDRESS_BITS_DEFAULT + patc_pkg::SUM_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output logic [QW-1:0] pop_data
);
  import patc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(QUEUE_DEPTH - 1);

  logic [QW-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == DEPTH_C);
  assign pop_valid = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/patc_back.sv
module patc_back #(
  parameter int ADDRESS_BITS = patc_pkg::ADDRESS_BITS_DEFAULT,
  parameter int QW = 6 * ADDRESS_BITS + patc_pkg::SUM_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  logic [QW-1:0] q_data,
  input  logic [31:0]   base_address,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   destination_address,
  output logic [15:0]   tcp_checksum
);
  import patc_pkg::*;

  logic [COUNT_W-1:0][ADDRESS_BITS-1:0] vecs;
  logic [SUM_W-1:0] q_partial;

  logic             v1, v2;
  logic             rdy1, rdy2, rdy3;
  logic [31:0]      sum_a, sum_b, sum_a_next, sum_b_next;
  logic [SUM_W-1:0] partial1, partial2;
  logic [31:0]      daddr;
  logic [SUM_W-1:0] total;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign {vecs, q_partial} = q_data;

  // Elastic stage control
  assign rdy3  = !out_valid || out_ready;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign q_pop = q_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= q_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  // Stage 1: weight the bit-plane vectors, fold in the base
  assign sum_a_next = 32'(vecs[0]) + (32'(vecs[1]) << 1)
                    + (32'(vecs[2]) << 2) + (32'(vecs[3]) << 3);
  assign sum_b_next = (32'(vecs[4]) << 4) + (32'(vecs[5]) << 5) + base_address;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sum_a    <= sum_a_next;
      sum_b    <= sum_b_next;
      partial1 <= q_partial;
    end
  end

  // Stage 2: destination address
  always_ff @(posedge clk) begin
    if (rdy2) begin
      daddr    <= sum_a + sum_b;
      partial2 <= partial1;
    end
  end

  // Stage 3: end-around carry fold and complement
  assign total = partial2 + SUM_W'(daddr[31:16]) + SUM_W'(daddr[15:0]);
  assign fold1 = 17'(total[SUM_W-1:16]) + 17'(total[15:0]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      destination_address <= daddr;
      tcp_checksum        <= ~fold2;
    end
  end

endmodule

FILE: hw/rtl/permuted_address_tcp_checksum.sv
// Permuted-address TCP SYN checksum generator.
//
// Input channel (in_valid/in_ready): a load beat (command 0) writes one
// entry of the bit-permutation table; it gives no result and takes effect
// for the next beat. A generate beat (command 1) yields one output beat with
// the destination address (base plus scattered counter bits) and the TCP
// checksum over pseudo-header and 20-byte SYN header.
// Output channel (out_valid/out_ready): one beat per generate beat, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// Path: a generate beat is written into the queue on the accepting edge,
// then passes three pipeline registers on its way to the output.
// Throughput: one beat per cycle unless out_ready stalls, set by the table
// lookup and bit-count front stage and three-stage adder pipeline behind it.
// Stall: when out_ready is low the pipeline fills, then the queue; in_ready
// falls once the two-entry queue is full and rises as soon as one entry
// leaves it.
// Reset (rst, synchronous): queue and pipeline empty, registers to their
// defaults; the permutation table keeps no reset and must be loaded.
module permuted_address_tcp_checksum #(
  parameter int ADDRESS_BITS = patc_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [4:0]  perm_index,
  input  logic [4:0]  perm_target,
  input  logic [31:0] counter,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] sequence_number,
  input  logic [31:0] ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] destination_address,
  output logic [15:0] tcp_checksum
);
  import patc_pkg::*;

  localparam int QW = COUNT_W * ADDRESS_BITS + SUM_W;

  logic [31:0]   base_address;
  logic [5:0]    host_bits;
  logic [15:0]   dest_port;
  logic [15:0]   window_size;
  logic          push, queue_full, q_valid, q_pop;
  logic [QW-1:0] push_data, q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_ADDRESS_RESET;
      host_bits    <= HOST_BITS_RESET;
      dest_port    <= DEST_PORT_RESET;
      window_size  <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_HOST_BITS:    host_bits    <= cfg_data[5:0];
        REG_DEST_PORT:    dest_port    <= cfg_data[15:0];
        REG_WINDOW_SIZE:  window_size  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  patc_front #(.ADDRESS_BITS(ADDRESS_BITS), .QW(QW)) u_front (
    .clk             (clk),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .perm_index      (perm_index),
    .perm_target     (perm_target),
    .counter         (counter),
    .source_address  (source_address),
    .source_port     (source_port),
    .sequence_number (sequence_number),
    .ack_number      (ack_number),
    .host_bits       (host_bits),
    .dest_port       (dest_port),
    .window_size     (window_size),
    .push            (push),
    .push_data       (push_data),
    .queue_full      (queue_full)
  );

  patc_queue #(.QW(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  patc_back #(.ADDRESS_BITS(ADDRESS_BITS), .QW(QW)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_data              (q_data),
    .base_address        (base_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .destination_address (destination_address),
    .tcp_checksum        (tcp_checksum)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import patc_pkg::*;

  // One generated header: destination address and its checksum
  typedef struct {
    logic [31:0] address;
    logic [15:0] checksum;
  } syn_header_t;

  // One input beat, all fields
  typedef struct {
    command_t    cmd;
    logic [4:0]  perm_index;
    logic [4:0]  perm_target;
    logic [31:0] counter;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
  } syn_beat_t;

  // Mirror of the block: registers, permutation table, headers still owed
  class checksum_board;
    logic [31:0] base_address;
    logic [5:0]  host_bits;
    logic [15:0] dest_port;
    logic [15:0] window_size;
    logic [4:0]  bit_targets [32];
    syn_header_t owed_headers [$];
    int          errors;

    function new();
      base_address = BASE_ADDRESS_RESET;
      host_bits    = HOST_BITS_RESET;
      dest_port    = DEST_PORT_RESET;
      window_size  = WINDOW_SIZE_RESET;
      errors       = 0;
      foreach (bit_targets[i]) bit_targets[i] = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_BASE_ADDRESS: base_address = data;
        REG_HOST_BITS:    host_bits    = data[5:0];
        REG_DEST_PORT:    dest_port    = data[15:0];
        REG_WINDOW_SIZE:  window_size  = data[15:0];
        default: ;
      endcase
    endfunction

    // Counter bits moved to their targets; colliding bits add and carry
    function logic [31:0] permuted_offset(logic [31:0] count);
      int          n;
      logic [31:0] acc;
      n   = (host_bits > 6'd32) ? 32 : int'(host_bits);
      acc = '0;
      for (int y = 0; y < n; y++) begin
        if (count[y]) acc = acc + (32'd1 << bit_targets[y]);
      end
      return acc;
    endfunction

    // Ones'-complement sum over pseudo-header and SYN header, then inverted
    function logic [15:0] header_checksum(syn_beat_t b, logic [31:0] daddr);
      logic [31:0] sum;
      sum = b.source_address[31:16] + b.source_address[15:0]
          + daddr[31:16] + daddr[15:0]
          + PROTO_WORD + TCP_LEN_WORD
          + b.source_port + dest_port
          + b.sequence_number[31:16] + b.sequence_number[15:0]
          + b.ack_number[31:16] + b.ack_number[15:0]
          + OFFSET_FLAGS_WORD + window_size;
      sum = sum[31:16] + sum[15:0];
      sum = sum + (sum >> 16);
      return ~sum[15:0];
    endfunction

    function void note_beat(syn_beat_t b);
      syn_header_t h;
      if (b.cmd == CMD_LOAD) begin
        bit_targets[b.perm_index] = b.perm_target;
      end else begin
        h.address  = base_address + permuted_offset(b.counter);
        h.checksum = header_checksum(b, h.address);
        owed_headers.push_back(h);
      end
    endfunction

    function void check_beat(logic [31:0] address, logic [15:0] checksum);
      syn_header_t h;
      if (owed_headers.size() == 0) begin
        $error("destination_address: got %h (tcp_checksum %h) with none expected",
               address, checksum);
        errors++;
        return;
      end
      h = owed_headers.pop_front();
      if (address !== h.address) begin
        $error("destination_address: expected %h, got %h", h.address, address);
        errors++;
      end
      if (checksum !== h.checksum) begin
        $error("tcp_checksum: expected %h, got %h", h.checksum, checksum);
        errors++;
      end
    endfunction

    function int pending();
      return owed_headers.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [4:0]  perm_index = '0;
  logic [4:0]  perm_target = '0;
  logic [31:0] counter = '0;
  logic [31:0] source_address = '0;
  logic [15:0] source_port = '0;
  logic [31:0] sequence_number = '0;
  logic [31:0] ack_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] destination_address;
  logic [15:0] tcp_checksum;

  checksum_board board = new();
  int unsigned   stall_clock = 0;

  always #5 clk = ~clk;

  permuted_address_tcp_checksum i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .command             (command),
    .perm_index          (perm_index),
    .perm_target         (perm_target),
    .counter             (counter),
    .source_address      (source_address),
    .source_port         (source_port),
    .sequence_number     (sequence_number),
    .ack_number          (ack_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .destination_address (destination_address),
    .tcp_checksum        (tcp_checksum)
  );

  // Receiver stall pattern: free, coin flip, mostly stalled, periodic
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    case ((stall_clock / 100) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_clock % 5) < 2);
    endcase
  end

  // Handshakes sampled mid-cycle; inputs are noted before outputs are checked
  always @(negedge clk) begin
    syn_beat_t b;
    if (!rst) begin
      if (in_valid && in_ready) begin
        b.cmd             = command_t'(command);
        b.perm_index      = perm_index;
        b.perm_target     = perm_target;
        b.counter         = counter;
        b.source_address  = source_address;
        b.source_port     = source_port;
        b.sequence_number = sequence_number;
        b.ack_number      = ack_number;
        board.note_beat(b);
      end
      if (out_valid && out_ready) board.check_beat(destination_address, tcp_checksum);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic syn_beat_t load_beat(int idx, int tgt);
    syn_beat_t b;
    b.cmd             = CMD_LOAD;
    b.perm_index      = idx[4:0];
    b.perm_target     = tgt[4:0];
    b.counter         = $urandom;
    b.source_address  = $urandom;
    b.source_port     = 16'($urandom);
    b.sequence_number = $urandom;
    b.ack_number      = $urandom;
    return b;
  endfunction

  function automatic syn_beat_t gen_beat(logic [31:0] count, logic [31:0] saddr,
                                         logic [15:0] sport, logic [31:0] seq,
                                         logic [31:0] ack);
    syn_beat_t b;
    b.cmd             = CMD_GENERATE;
    b.perm_index      = 5'($urandom);
    b.perm_target     = 5'($urandom);
    b.counter         = count;
    b.source_address  = saddr;
    b.source_port     = sport;
    b.sequence_number = seq;
    b.ack_number      = ack;
    return b;
  endfunction

  function automatic syn_beat_t random_beat(int load_pct);
    if ($urandom_range(0, 99) < load_pct)
      return load_beat($urandom_range(0, 31), $urandom_range(0, 31));
    return gen_beat(pick_word(), pick_word(), 16'(pick_word()), pick_word(), pick_word());
  endfunction

  // Present a beat and hold it until accepted; valid stays high afterward
  task automatic send_beat(syn_beat_t b);
    logic taken;
    in_valid        <= 1'b1;
    command         <= b.cmd;
    perm_index      <= b.perm_index;
    perm_target     <= b.perm_target;
    counter         <= b.counter;
    source_address  <= b.source_address;
    source_port     <= b.source_port;
    sequence_number <= b.sequence_number;
    ack_number      <= b.ack_number;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait for every owed header, then let any trailing load settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_settings();
    logic [31:0] hb;
    case ($urandom_range(0, 7))
      0: hb = 0;
      1: hb = 32;
      2: hb = 63;
      3: hb = 1;
      4: hb = 33;
      default: hb = $urandom_range(0, 63);
    endcase
    write_reg(REG_BASE_ADDRESS, pick_word());
    write_reg(REG_HOST_BITS, hb);
    write_reg(REG_DEST_PORT, {16'h0, 16'(pick_word())});
    write_reg(REG_WINDOW_SIZE, {16'h0, 16'(pick_word())});
  endtask

  // Main stimulus
  initial begin
    int sent;
    int phase_len;
    int load_pct;
    int burst_left;
    bit gapless;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table first so no generate reads an unwritten entry
    for (int e = 0; e < 32; e++) send_beat(load_beat(e, e));

    // Reset settings, field extremes; table fields ignored on generate
    send_beat(gen_beat('0, '0, '0, '0, '0));
    send_beat(gen_beat('1, '1, 16'hffff, '1, '1));
    send_beat(gen_beat(32'h0000_005a, 32'hc0a8_0001, 16'd1024, 32'h1234_5678, '0));

    // Colliding targets: two bits at 31 wrap away, two bits at 3 carry to 4
    send_beat(load_beat(0, 31));
    send_beat(load_beat(1, 31));
    send_beat(load_beat(2, 3));
    send_beat(load_beat(3, 3));
    send_beat(gen_beat(32'h0000_000f, 32'h0a00_0001, 16'd80, '1, '0));
    send_beat(gen_beat(32'h0000_0003, '0, '0, '0, '0));
    send_beat(gen_beat(32'h0000_0005, 32'h8000_0000, 16'h8000, 32'h8000_0000, 32'h1));
    drain();

    // No permuted bits: address is the base
    write_reg(REG_BASE_ADDRESS, 32'hffff_ffff);
    write_reg(REG_HOST_BITS, 32'd0);
    write_reg(REG_DEST_PORT, 32'h0000_ffff);
    write_reg(REG_WINDOW_SIZE, 32'h0000_ffff);
    send_beat(gen_beat('1, '1, 16'hffff, '1, '1));
    send_beat(gen_beat('0, '0, '0, '0, '0));
    drain();

    // Oversized host_bits clamps to the address width
    write_reg(REG_HOST_BITS, 32'd63);
    send_beat(gen_beat('1, 32'h1234_5678, 16'h0001, 32'hdead_beef, 32'h0bad_f00d));
    drain();
    write_reg(REG_HOST_BITS, 32'd32);
    write_reg(REG_BASE_ADDRESS, 32'h0);
    send_beat(gen_beat(32'h8000_0001, '0, '0, '0, '0));
    drain();
    write_reg(REG_HOST_BITS, 32'd1);
    write_reg(REG_WINDOW_SIZE, 32'h0);
    write_reg(REG_DEST_PORT, 32'h0);
    send_beat(gen_beat(32'h0000_0003, '1, 16'hffff, '1, '1));
    drain();

    // Random phases: new settings, then bursts with mixed loads and generates
    sent = 0;
    while (sent < 400) begin
      random_settings();
      phase_len  = $urandom_range(20, 60);
      load_pct   = $urandom_range(5, 40);
      gapless    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (int k = 0; k < phase_len; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (!gapless) pause_input($urandom_range(1, 5));
        end
        send_beat(random_beat(load_pct));
        burst_left--;
        sent++;
      end
      drain();
    end

    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/patc_pkg.sv
hw/rtl/patc_front.sv
hw/rtl/patc_queue.sv
hw/rtl/patc_back.sv
hw/rtl/permuted_address_tcp_checksum.sv
tb/testbench.sv
